/* hw/rtl/rpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants for the retrieval pointer decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [15:0] MAX_EXT_RESET = 16'hffff;
  localparam logic        REG_EXT_CAP   = 1'b0;

  localparam logic [1:0] MODE_WORD = 2'd0;
  localparam logic [1:0] MODE_LAST = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  localparam logic [1:0] FMT_PLACE = 2'd0;
  localparam logic [1:0] FMT_ONE   = 2'd1;
  localparam logic [1:0] FMT_TWO   = 2'd2;

  typedef enum logic [1:0] {
    KIND_EXTENT    = 2'd0,
    KIND_END_OK    = 2'd1,
    KIND_END_TRUNC = 2'd2
  } kind_t;

  typedef struct packed {
    logic        ext_vld;
    logic [31:0] start_block;
    logic [30:0] block_total;
    logic [15:0] extent_total;
    logic        end_vld;
    logic        trunc;
  } entry_t;

endpackage
`default_nettype wire

/* hw/rtl/rpd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_front
// Accepts map words, tracks pointer phase, queues extent and end entries.
// ----------------------------------------------------------------------------
module rpd_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_mode,
  input  wire logic [15:0]          in_map_word,
  input  wire logic [15:0]          ext_cap,
  input  wire logic                 q_full,
  output logic                      q_push,
  output rpd_pkg::entry_t           q_data
);

  logic [1:0]  wl_r, wl_nxt, wl_a, wl_dec, pos;
  logic [1:0]  fmt_r, fmt_nxt, fmt_a;
  logic [13:0] lead_r, lead_nxt, lead_a;
  logic [15:0] w2_r, w2_nxt, w2_a;
  logic [15:0] w3_r, w3_nxt, w3_a;
  logic [15:0] cnt_r, cnt_nxt, cnt_a;
  logic        is_word, is_end, ext, accept;
  logic [31:0] start;
  logic [30:0] blocks;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_word = in_mode inside {rpd_pkg::MODE_WORD, rpd_pkg::MODE_LAST};
    is_end  = in_mode != rpd_pkg::MODE_WORD;
    wl_a    = wl_r;
    fmt_a   = fmt_r;
    lead_a  = lead_r;
    w2_a    = w2_r;
    w3_a    = w3_r;
    cnt_a   = cnt_r;
    ext     = 1'b0;
    start   = '0;
    blocks  = '0;
    pos     = fmt_r - wl_r;
    wl_dec  = wl_r - 2'd1;
    if (is_word) begin
      if (wl_r == 2'd0) begin
        if (in_map_word[15:14] != rpd_pkg::FMT_PLACE) begin
          fmt_a  = in_map_word[15:14];
          lead_a = in_map_word[13:0];
          wl_a   = in_map_word[15:14];
        end
      end else begin
        wl_a = wl_dec;
        if (wl_dec != 2'd0) begin
          if (pos == 2'd0) begin
            w2_a = in_map_word;
          end else begin
            w3_a = in_map_word;
          end
        end else begin
          case (fmt_r)
            rpd_pkg::FMT_ONE: begin
              start  = {10'd0, lead_r[13:8], in_map_word};
              blocks = {23'd0, lead_r[7:0]} + 31'd1;
            end
            rpd_pkg::FMT_TWO: begin
              start  = {in_map_word, w2_r};
              blocks = {17'd0, lead_r} + 31'd1;
            end
            default: begin
              start  = {in_map_word, w3_r};
              blocks = {1'b0, lead_r, w2_r} + 31'd1;
            end
          endcase
          if (cnt_r < ext_cap) begin
            ext   = 1'b1;
            cnt_a = cnt_r + 16'd1;
          end
        end
      end
    end
  end

  always_comb begin
    q_push              = accept && (ext || is_end);
    q_data.ext_vld      = ext;
    q_data.start_block  = start;
    q_data.block_total  = blocks;
    q_data.extent_total = cnt_a;
    q_data.end_vld      = is_end;
    q_data.trunc        = wl_a != 2'd0;
  end

  always_comb begin
    wl_nxt   = wl_r;
    fmt_nxt  = fmt_r;
    lead_nxt = lead_r;
    w2_nxt   = w2_r;
    w3_nxt   = w3_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (is_end) begin
        wl_nxt   = '0;
        fmt_nxt  = '0;
        lead_nxt = '0;
        w2_nxt   = '0;
        w3_nxt   = '0;
        cnt_nxt  = '0;
      end else begin
        wl_nxt   = wl_a;
        fmt_nxt  = fmt_a;
        lead_nxt = lead_a;
        w2_nxt   = w2_a;
        w3_nxt   = w3_a;
        cnt_nxt  = cnt_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= '0;
      fmt_r  <= '0;
      lead_r <= '0;
      w2_r   <= '0;
      w3_r   <= '0;
      cnt_r  <= '0;
    end else begin
      wl_r   <= wl_nxt;
      fmt_r  <= fmt_nxt;
      lead_r <= lead_nxt;
      w2_r   <= w2_nxt;
      w3_r   <= w3_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_wl_le_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    wl_r <= fmt_r)
    else $error("words left exceeds pointer format");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_end |=> wl_r == 2'd0 && cnt_r == 16'd0)
    else $error("run state not cleared after end of map");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_end && !ext |=> cnt_r == $past(cnt_r))
    else $error("extent count moved without an extent");

endmodule
`default_nettype wire

/* hw/rtl/rpd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_queue
// Short register queue of result entries between front and back.
// ----------------------------------------------------------------------------
module rpd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rpd_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output rpd_pkg::entry_t      head,
  output logic                 not_empty
);

  rpd_pkg::entry_t                mem [rpd_pkg::QDEPTH];
  logic [rpd_pkg::QPTR_W-1:0]     wr_r, wr_nxt, rd_r, rd_nxt;
  logic [rpd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full      = cnt_r == rpd_pkg::QCNT_W'(rpd_pkg::QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + rpd_pkg::QCNT_W'(push) - rpd_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty))
    else $error("queue pop while empty");

  a_entry_useful: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_data.ext_vld || push_data.end_vld)
    else $error("queue entry carries no result");

endmodule
`default_nettype wire

/* hw/rtl/rpd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpd_back
// Drains queue entries into the output register, extent word before end word.
// ----------------------------------------------------------------------------
module rpd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_vld,
  input  wire rpd_pkg::entry_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           out_kind,
  output logic [31:0]          out_start_block,
  output logic [30:0]          out_block_total,
  output logic [15:0]          out_extent_total,
  output logic                 out_final_res
);

  logic        vld_r, vld_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] start_r, start_nxt;
  logic [30:0] blocks_r, blocks_nxt;
  logic [15:0] total_r, total_nxt;
  logic        fin_r, fin_nxt;
  logic        pend_r, pend_nxt;
  logic        pend_trunc_r, pend_trunc_nxt;
  logic [15:0] pend_total_r, pend_total_nxt;
  logic        load;

  rpd_pkg::kind_t head_end_kind, pend_kind;

  assign load          = !vld_r || out_ready;
  assign head_end_kind = q_head.trunc ? rpd_pkg::KIND_END_TRUNC : rpd_pkg::KIND_END_OK;
  assign pend_kind     = pend_trunc_r ? rpd_pkg::KIND_END_TRUNC : rpd_pkg::KIND_END_OK;

  always_comb begin
    vld_nxt        = vld_r;
    kind_nxt       = kind_r;
    start_nxt      = start_r;
    blocks_nxt     = blocks_r;
    total_nxt      = total_r;
    fin_nxt        = fin_r;
    pend_nxt       = pend_r;
    pend_trunc_nxt = pend_trunc_r;
    pend_total_nxt = pend_total_r;
    q_pop          = 1'b0;
    if (load) begin
      if (pend_r) begin
        vld_nxt    = 1'b1;
        kind_nxt   = pend_kind;
        start_nxt  = '0;
        blocks_nxt = '0;
        total_nxt  = pend_total_r;
        fin_nxt    = 1'b1;
        pend_nxt   = 1'b0;
      end else if (q_vld) begin
        q_pop     = 1'b1;
        vld_nxt   = 1'b1;
        total_nxt = q_head.extent_total;
        if (q_head.ext_vld) begin
          kind_nxt       = rpd_pkg::KIND_EXTENT;
          start_nxt      = q_head.start_block;
          blocks_nxt     = q_head.block_total;
          fin_nxt        = 1'b0;
          pend_nxt       = q_head.end_vld;
          pend_trunc_nxt = q_head.trunc;
          pend_total_nxt = q_head.extent_total;
        end else begin
          kind_nxt   = head_end_kind;
          start_nxt  = '0;
          blocks_nxt = '0;
          fin_nxt    = 1'b1;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    start_r      <= start_nxt;
    blocks_r     <= blocks_nxt;
    total_r      <= total_nxt;
    fin_r        <= fin_nxt;
    pend_trunc_r <= pend_trunc_nxt;
    pend_total_r <= pend_total_nxt;
  end

  assign out_valid        = vld_r;
  assign out_kind         = kind_r;
  assign out_start_block  = start_r;
  assign out_block_total  = blocks_r;
  assign out_extent_total = total_r;
  assign out_final_res    = fin_r;

  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> vld_r && !fin_r)
    else $error("pending end word without extent word in output");

  a_pend_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !q_pop)
    else $error("queue popped while end word pending");

  a_fin_no_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && fin_r |-> blocks_r == 31'd0 && start_r == 32'd0)
    else $error("end word carries extent data");

endmodule
`default_nettype wire

/* hw/rtl/retrieval_pointer_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// retrieval_pointer_decoder
// Decodes file map words into extent words and one end-of-map word per run.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_mode, in_map_word
//   out      output     out_valid / out_ready   out_kind .. out_final_res
//   cfg      input      APB psel/penable        extent cap at address 0
//
// One map word accepted per cycle while the result queue is not full; the front decode is combinational.
// A word that gives an extent and ends the map yields an extent word, then an end word, on the output.
// A four-entry result queue lets input run ahead while output stalls.
// Synchronous reset; no clearing pass, ready as soon as reset is released.
// ----------------------------------------------------------------------------
module retrieval_pointer_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_map_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_start_block,
  output logic [30:0]      out_block_total,
  output logic [15:0]      out_extent_total,
  output logic             out_final_res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]     max_r, max_nxt;
  logic            q_full, q_push, q_pop, q_vld;
  rpd_pkg::entry_t q_data, q_head;

  assign pready = 1'b1;

  always_comb begin
    max_nxt = max_r;
    if (psel && penable && pwrite && paddr[2] == rpd_pkg::REG_EXT_CAP) begin
      max_nxt = pwdata[15:0];
    end
    prdata = (paddr[2] == rpd_pkg::REG_EXT_CAP) ? {16'd0, max_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= rpd_pkg::MAX_EXT_RESET;
    end else begin
      max_r <= max_nxt;
    end
  end

  rpd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_map_word (in_map_word),
    .ext_cap     (max_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  rpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_vld)
  );

  rpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_vld            (q_vld),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_start_block  (out_start_block),
    .out_block_total  (out_block_total),
    .out_extent_total (out_extent_total),
    .out_final_res    (out_final_res)
  );

endmodule
`default_nettype wire
